### hdl/hgca_pkg.sv
`default_nettype none

package hgca_pkg;

  // channel and gain formats
  localparam int CHAN_W  = 8;
  localparam int GAIN_W  = 11;
  localparam int FRAC_W  = 10;
  localparam int TDATA_W = 3 * CHAN_W;

  // hue in 1/64 degree
  localparam int DEG60  = 3840;
  localparam int DEG120 = 7680;
  localparam int DEG360 = 23040;
  localparam int HUE_W  = 15;

  // floor(y/15) = (y * RECIP15) >> RECIP_SH, exact for y < 2^22
  localparam int RECIP15  = 4473925;
  localparam int RECIP_SH = 26;

  // pipeline length
  localparam int NST     = 19;
  localparam int DIV_NST = 6;

  // configuration register indexes
  localparam logic [1:0] CFG_HUE_GAIN = 2'd0;
  localparam logic [1:0] CFG_SAT_GAIN = 2'd1;
  localparam logic [1:0] CFG_VAL_GAIN = 2'd2;

  localparam logic [GAIN_W-1:0] HUE_GAIN_RST = 11'd102;
  localparam logic [GAIN_W-1:0] SAT_GAIN_RST = 11'd768;
  localparam logic [GAIN_W-1:0] VAL_GAIN_RST = 11'd768;

  // which channel holds the maximum
  typedef enum logic [1:0] {
    MAX_R = 2'd0,
    MAX_G = 2'd1,
    MAX_B = 2'd2
  } maxsrc_t;

  // one item inside the hue divider
  typedef struct packed {
    logic [19:0] rem;
    logic [11:0] q;
    logic [7:0]  diff;
    maxsrc_t     sel;
    logic        neg;
    logic [29:0] ch;
    logic [29:0] m;
  } dv_t;

  // one restoring division step on quotient bit b
  function automatic dv_t div_step(dv_t a, logic [3:0] b);
    logic [19:0] trial;
    dv_t         o;
    o     = a;
    trial = 20'(a.diff) << b;
    if (a.rem >= trial) begin
      o.rem  = a.rem - trial;
      o.q[b] = 1'b1;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

### hdl/hsv_gain_color_adjust_core.sv
`default_nettype none

// HSV gain colour adjust. Each RGB pixel is taken to hue / saturation / value,
// the three are scaled by the hue, saturation and value gains (unsigned, 10
// fraction bits) and the pixel is rebuilt by the six-sector chroma / X / m rule,
// each channel truncated and saturated to 0..255. A gray pixel has hue 0 and no
// chroma, a scaled hue at or above 360 degrees wraps, and chroma never exceeds
// value. The block is a 19-stage pipeline: one pixel per clock enters while
// in_tready is high. Each stage has its own valid bit and holds its item while
// the stage after it is full and cannot load, so a stalled output does not stop
// transfers into empty stages. The hue quotient comes from a six-stage restoring
// divider, two quotient bits per stage; the chroma times (60 - distance) / 60
// step uses a reciprocal multiply by 1/15 after a shift. The user must write
// gains through the cfg port only while no pixel is in flight; the block does
// not enforce this, and cfg_ready is always high.
module hsv_gain_color_adjust_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // config write channel
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [hgca_pkg::GAIN_W-1:0] cfg_data,
  // pixel input
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [hgca_pkg::TDATA_W-1:0] in_tdata,  // red_in, green_in, blue_in
  // pixel output
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [hgca_pkg::TDATA_W-1:0]     out_tdata   // red_out, green_out, blue_out
);

  localparam int N = hgca_pkg::NST;

  // gain registers
  logic [hgca_pkg::GAIN_W-1:0] hue_gain_r, sat_gain_r, val_gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_gain_r <= hgca_pkg::HUE_GAIN_RST;
      sat_gain_r <= hgca_pkg::SAT_GAIN_RST;
      val_gain_r <= hgca_pkg::VAL_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hgca_pkg::CFG_HUE_GAIN: hue_gain_r <= cfg_data;
        hgca_pkg::CFG_SAT_GAIN: sat_gain_r <= cfg_data;
        hgca_pkg::CFG_VAL_GAIN: val_gain_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valids and per-stage load enables
  logic [N-1:0] vld_r, vld_nxt, en;

  always_comb begin
    en[N-1] = !vld_r[N-1] || out_tready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign vld_nxt   = (en & {vld_r[N-2:0], in_tvalid}) | (~en & vld_r);
  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= vld_nxt;
  end

  // stage 0: capture pixel
  logic [7:0] s0_r_r, s0_g_r, s0_b_r;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_r_r <= in_tdata[7:0];
      s0_g_r <= in_tdata[15:8];
      s0_b_r <= in_tdata[23:16];
    end
  end

  // stage 1: max, min, hue numerator
  logic [7:0]         mx_nxt, mn_nxt, mag_nxt;
  logic signed [8:0]  num_nxt;
  hgca_pkg::maxsrc_t  sel_nxt;
  logic [7:0]         s1_mx_r, s1_diff_r, s1_mag_r;
  hgca_pkg::maxsrc_t  s1_sel_r;
  logic               s1_neg_r;

  always_comb begin
    mx_nxt = s0_r_r;
    mn_nxt = s0_r_r;
    if (s0_g_r > mx_nxt) mx_nxt = s0_g_r;
    if (s0_b_r > mx_nxt) mx_nxt = s0_b_r;
    if (s0_g_r < mn_nxt) mn_nxt = s0_g_r;
    if (s0_b_r < mn_nxt) mn_nxt = s0_b_r;
    // ties favour red, then green
    if (mx_nxt == s0_r_r) begin
      sel_nxt = hgca_pkg::MAX_R;
      num_nxt = $signed({1'b0, s0_g_r}) - $signed({1'b0, s0_b_r});
    end else if (mx_nxt == s0_g_r) begin
      sel_nxt = hgca_pkg::MAX_G;
      num_nxt = $signed({1'b0, s0_b_r}) - $signed({1'b0, s0_r_r});
    end else begin
      sel_nxt = hgca_pkg::MAX_B;
      num_nxt = $signed({1'b0, s0_r_r}) - $signed({1'b0, s0_g_r});
    end
    mag_nxt = num_nxt[8] ? 8'(-num_nxt) : num_nxt[7:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_mx_r   <= mx_nxt;
      s1_diff_r <= mx_nxt - mn_nxt;
      s1_mag_r  <= mag_nxt;
      s1_sel_r  <= sel_nxt;
      s1_neg_r  <= num_nxt[8];
    end
  end

  // stage 2: dividend, value times value gain and diff times saturation gain
  logic [19:0]       s2_n_r;
  logic [18:0]       s2_v_r, s2_cs_r;
  logic [7:0]        s2_diff_r;
  hgca_pkg::maxsrc_t s2_sel_r;
  logic              s2_neg_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_n_r    <= 20'(s1_mag_r) * 20'(hgca_pkg::DEG60);
      s2_v_r    <= 19'(s1_mx_r) * 19'(val_gain_r);
      s2_cs_r   <= 19'(s1_diff_r) * 19'(sat_gain_r);
      s2_diff_r <= s1_diff_r;
      s2_sel_r  <= s1_sel_r;
      s2_neg_r  <= s1_neg_r;
    end
  end

  // stage 3: raw chroma and full-scale value
  logic [19:0]       s3_n_r;
  logic [29:0]       s3_chr_r, s3_bigv_r;
  logic [7:0]        s3_diff_r;
  hgca_pkg::maxsrc_t s3_sel_r;
  logic              s3_neg_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_n_r    <= s2_n_r;
      s3_chr_r  <= 30'(s2_cs_r) * 30'(val_gain_r);
      s3_bigv_r <= {1'b0, s2_v_r, 10'b0};
      s3_diff_r <= s2_diff_r;
      s3_sel_r  <= s2_sel_r;
      s3_neg_r  <= s2_neg_r;
    end
  end

  // stage 4: clamp chroma to value, m = V - C; enters the divider
  hgca_pkg::dv_t s4_r, s4_nxt;
  logic [29:0]   ch_cl;

  always_comb begin
    ch_cl         = (s3_chr_r > s3_bigv_r) ? s3_bigv_r : s3_chr_r;
    s4_nxt.rem    = s3_n_r;
    s4_nxt.q      = '0;
    s4_nxt.diff   = s3_diff_r;
    s4_nxt.sel    = s3_sel_r;
    s4_nxt.neg    = s3_neg_r;
    s4_nxt.ch     = ch_cl;
    s4_nxt.m      = s3_bigv_r - ch_cl;
  end

  always_ff @(posedge clk) begin
    if (en[4]) s4_r <= s4_nxt;
  end

  // stages 5..10: restoring divider, two quotient bits per stage
  hgca_pkg::dv_t dv_r   [hgca_pkg::DIV_NST];
  hgca_pkg::dv_t dv_src [hgca_pkg::DIV_NST];
  hgca_pkg::dv_t dv_nxt [hgca_pkg::DIV_NST];

  assign dv_src[0] = s4_r;

  for (genvar s = 0; s < hgca_pkg::DIV_NST; s++) begin : g_div
    if (s > 0) begin : g_link
      assign dv_src[s] = dv_r[s-1];
    end
    always_comb begin
      dv_nxt[s] = hgca_pkg::div_step(
                    hgca_pkg::div_step(dv_src[s], 4'(11 - 2 * s)), 4'(10 - 2 * s));
    end
    always_ff @(posedge clk) begin
      if (en[5+s]) dv_r[s] <= dv_nxt[s];
    end
  end

  localparam int DL = hgca_pkg::DIV_NST - 1;

  // stage 11: hue assembly, chroma / 3840 quotient
  logic signed [16:0] hue_s;
  logic [14:0]        hue_nxt;
  logic [44:0]        qcp;
  logic [14:0]        s11_hue_r;
  logic [17:0]        s11_qc_r;
  logic [29:0]        s11_ch_r, s11_m_r;

  always_comb begin
    case (dv_r[DL].sel)
      hgca_pkg::MAX_G: hue_s = 17'sd7680;
      hgca_pkg::MAX_B: hue_s = 17'sd15360;
      default:         hue_s = 17'sd0;
    endcase
    if (dv_r[DL].neg) hue_s = hue_s - $signed({5'b0, dv_r[DL].q});
    else              hue_s = hue_s + $signed({5'b0, dv_r[DL].q});
    if (hue_s < 0) hue_s = hue_s + 17'(hgca_pkg::DEG360);
    // gray pixel has no hue
    hue_nxt = (dv_r[DL].diff == 8'd0) ? 15'd0 : hue_s[14:0];
    qcp     = 45'(dv_r[DL].ch[29:8]) * 45'(hgca_pkg::RECIP15);
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      s11_hue_r <= hue_nxt;
      s11_qc_r  <= qcp[43:26];
      s11_ch_r  <= dv_r[DL].ch;
      s11_m_r   <= dv_r[DL].m;
    end
  end

  // stage 12: hue times gain, chroma remainder
  logic [25:0] s12_prod_r;
  logic [29:0] rc_full;
  logic [11:0] s12_rc_r;
  logic [17:0] s12_qc_r;
  logic [29:0] s12_ch_r, s12_m_r;

  assign rc_full = s11_ch_r - 30'(s11_qc_r) * 30'(hgca_pkg::DEG60);

  always_ff @(posedge clk) begin
    if (en[12]) begin
      s12_prod_r <= 26'(s11_hue_r) * 26'(hue_gain_r);
      s12_rc_r   <= rc_full[11:0];
      s12_qc_r   <= s11_qc_r;
      s12_ch_r   <= s11_ch_r;
      s12_m_r    <= s11_m_r;
    end
  end

  // stage 13: scaled hue, wrapped below 360 degrees
  logic [15:0] hs0;
  logic [15:0] hs_w;
  logic [14:0] s13_hs_r;
  logic [11:0] s13_rc_r;
  logic [17:0] s13_qc_r;
  logic [29:0] s13_ch_r, s13_m_r;

  assign hs0  = s12_prod_r[25:10];
  assign hs_w = (hs0 >= 16'(hgca_pkg::DEG360)) ? hs0 - 16'(hgca_pkg::DEG360) : hs0;

  always_ff @(posedge clk) begin
    if (en[13]) begin
      s13_hs_r <= hs_w[14:0];
      s13_rc_r <= s12_rc_r;
      s13_qc_r <= s12_qc_r;
      s13_ch_r <= s12_ch_r;
      s13_m_r  <= s12_m_r;
    end
  end

  // stage 14: sector and X weight (60 degrees minus distance to the nearest odd multiple of 60 degrees)
  logic [2:0]  sec_nxt;
  logic [14:0] sec_lo;
  logic [14:0] w_full;
  logic [2:0]  s14_sec_r;
  logic [11:0] s14_w_r, s14_rc_r;
  logic [17:0] s14_qc_r;
  logic [29:0] s14_ch_r, s14_m_r;

  always_comb begin
    sec_nxt = 3'd0;
    for (int k = 1; k < 6; k++) begin
      if (s13_hs_r >= 15'(k * hgca_pkg::DEG60)) sec_nxt = 3'(k);
    end
    sec_lo = 15'(sec_nxt) * 15'(hgca_pkg::DEG60);
    if (sec_nxt[0]) w_full = sec_lo + 15'(hgca_pkg::DEG60) - s13_hs_r;
    else            w_full = s13_hs_r - sec_lo;
  end

  always_ff @(posedge clk) begin
    if (en[14]) begin
      s14_sec_r <= sec_nxt;
      s14_w_r   <= w_full[11:0];
      s14_rc_r  <= s13_rc_r;
      s14_qc_r  <= s13_qc_r;
      s14_ch_r  <= s13_ch_r;
      s14_m_r   <= s13_m_r;
    end
  end

  // stage 15: partial products of chroma times weight
  logic [29:0] s15_qcw_r;
  logic [23:0] s15_rcw_r;
  logic [2:0]  s15_sec_r;
  logic [29:0] s15_ch_r, s15_m_r;

  always_ff @(posedge clk) begin
    if (en[15]) begin
      s15_qcw_r <= 30'(s14_qc_r) * 30'(s14_w_r);
      s15_rcw_r <= 24'(s14_rc_r) * 24'(s14_w_r);
      s15_sec_r <= s14_sec_r;
      s15_ch_r  <= s14_ch_r;
      s15_m_r   <= s14_m_r;
    end
  end

  // stage 16: remainder part divided by 3840
  logic [38:0] xlp;
  logic [11:0] s16_xl_r;
  logic [29:0] s16_qcw_r;
  logic [2:0]  s16_sec_r;
  logic [29:0] s16_ch_r, s16_m_r;

  assign xlp = 39'(s15_rcw_r[23:8]) * 39'(hgca_pkg::RECIP15);

  always_ff @(posedge clk) begin
    if (en[16]) begin
      s16_xl_r  <= xlp[37:26];
      s16_qcw_r <= s15_qcw_r;
      s16_sec_r <= s15_sec_r;
      s16_ch_r  <= s15_ch_r;
      s16_m_r   <= s15_m_r;
    end
  end

  // stage 17: X
  logic [29:0] s17_x_r;
  logic [2:0]  s17_sec_r;
  logic [29:0] s17_ch_r, s17_m_r;

  always_ff @(posedge clk) begin
    if (en[17]) begin
      s17_x_r   <= s16_qcw_r + 30'(s16_xl_r);
      s17_sec_r <= s16_sec_r;
      s17_ch_r  <= s16_ch_r;
      s17_m_r   <= s16_m_r;
    end
  end

  // stage 18: sector mux, add m, drop fraction, saturate
  logic [29:0] ro, go, bo;
  logic [30:0] rs, gs, bs;
  logic [7:0]  ro_nxt, go_nxt, bo_nxt;
  logic [7:0]  s18_r_r, s18_g_r, s18_b_r;

  always_comb begin
    case (s17_sec_r)
      3'd0:    begin ro = s17_ch_r; go = s17_x_r;  bo = '0;       end
      3'd1:    begin ro = s17_x_r;  go = s17_ch_r; bo = '0;       end
      3'd2:    begin ro = '0;       go = s17_ch_r; bo = s17_x_r;  end
      3'd3:    begin ro = '0;       go = s17_x_r;  bo = s17_ch_r; end
      3'd4:    begin ro = s17_x_r;  go = '0;       bo = s17_ch_r; end
      default: begin ro = s17_ch_r; go = '0;       bo = s17_x_r;  end
    endcase
    rs = 31'(ro) + 31'(s17_m_r);
    gs = 31'(go) + 31'(s17_m_r);
    bs = 31'(bo) + 31'(s17_m_r);
    ro_nxt = (rs[30:20] > 11'd255) ? 8'd255 : rs[27:20];
    go_nxt = (gs[30:20] > 11'd255) ? 8'd255 : gs[27:20];
    bo_nxt = (bs[30:20] > 11'd255) ? 8'd255 : bs[27:20];
  end

  always_ff @(posedge clk) begin
    if (en[18]) begin
      s18_r_r <= ro_nxt;
      s18_g_r <= go_nxt;
      s18_b_r <= bo_nxt;
    end
  end

  assign out_tvalid = vld_r[N-1];
  assign out_tdata  = {s18_b_r, s18_g_r, s18_r_r};

  // checks
  a_rst_clears: assert property (@(posedge clk) !rst_n |=> vld_r == '0)
    else $error("pipeline valid bits not cleared by reset");

  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted pixel not held in first stage");

  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[10] && dv_r[DL].diff != 8'd0 |->
      dv_r[DL].q <= 12'(hgca_pkg::DEG60) && dv_r[DL].rem < 20'(dv_r[DL].diff))
    else $error("hue divider result out of range");

  a_hue_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[13] |-> s13_hs_r < 15'(hgca_pkg::DEG360))
    else $error("scaled hue not wrapped");

  a_weight: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[14] |-> s14_w_r <= 12'(hgca_pkg::DEG60) && s14_sec_r <= 3'd5)
    else $error("sector or weight out of range");

  a_x_le_c: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[17] |-> s17_x_r <= s17_ch_r)
    else $error("X exceeds chroma");

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = hgca_pkg::CFG_HUE_GAIN;
  logic [hgca_pkg::GAIN_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [hgca_pkg::TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [hgca_pkg::TDATA_W-1:0] out_tdata;

  always #2 clk = ~clk;

  hsv_gain_color_adjust_core DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // gain copies held by the predictor
  logic [hgca_pkg::GAIN_W-1:0] hue_g, sat_g, val_g;

  pixel_t pending_px[$];   // pixels waiting to be sent
  pixel_t adjusted_px[$];  // predicted pixels not yet seen
  int errors = 0;
  int cycles = 0;
  bit send_hold = 1'b0;    // sender paused by the stimulus process

  function automatic logic [7:0] chan_sat(longint unsigned v);
    longint unsigned s;
    s = v >> (2 * hgca_pkg::FRAC_W);
    return (s > 255) ? 8'hff : s[7:0];
  endfunction

  // predicted adjusted pixel for one input
  function automatic pixel_t adjust_pixel(pixel_t p);
    longint r, g, b, mx, mn, diff, hue, num;
    longint unsigned hs, t, hdist, bigv, ch, x, m, rc, gc, bc;
    pixel_t o;
    r = p.red; g = p.green; b = p.blue;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    diff = mx - mn;
    hue = 0;
    if (diff != 0) begin
      // ties favour red, then green; truncation toward zero
      if (mx == r) begin num = g - b; hue = 0; end
      else if (mx == g) begin num = b - r; hue = hgca_pkg::DEG120; end
      else begin num = r - g; hue = 2 * hgca_pkg::DEG120; end
      if (num < 0) hue = hue - ((-num) * hgca_pkg::DEG60) / diff;
      else hue = hue + (num * hgca_pkg::DEG60) / diff;
      if (hue < 0) hue = hue + hgca_pkg::DEG360;
    end
    hs = ((longint'(hue) * hue_g) >> hgca_pkg::FRAC_W) % hgca_pkg::DEG360;
    bigv = (longint'(mx) * val_g) << hgca_pkg::FRAC_W;
    ch = longint'(diff) * sat_g * val_g;
    if (ch > bigv) ch = bigv;  // saturation above one
    m = bigv - ch;
    t = hs % hgca_pkg::DEG120;
    hdist = (t >= hgca_pkg::DEG60) ? t - hgca_pkg::DEG60 : hgca_pkg::DEG60 - t;
    x = (ch * (hgca_pkg::DEG60 - hdist)) / hgca_pkg::DEG60;
    case (hs / hgca_pkg::DEG60)
      0: begin rc = ch; gc = x; bc = 0; end
      1: begin rc = x; gc = ch; bc = 0; end
      2: begin rc = 0; gc = ch; bc = x; end
      3: begin rc = 0; gc = x; bc = ch; end
      4: begin rc = x; gc = 0; bc = ch; end
      default: begin rc = ch; gc = 0; bc = x; end
    endcase
    o.red = chan_sat(rc + m);
    o.green = chan_sat(gc + m);
    o.blue = chan_sat(bc + m);
    return o;
  endfunction

  // driver: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        adjusted_px.push_back(adjust_pixel(pixel_t'(in_tdata)));
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_px.size() > 0 && !send_hold) begin
          in_tdata <= pending_px.pop_front();
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern: phases of full rate, random and heavy stalls
  always @(posedge clk) begin
    case ((cycles / 300) % 3)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // monitor
  always @(posedge clk) begin
    pixel_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = pixel_t'(out_tdata);
      if (adjusted_px.size() == 0) begin
        $display("%0t: unexpected transfer, expected none actual %h", $time, got);
        errors <= errors + 1;
      end else begin
        want = adjusted_px.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
          $display("%0t: pixel mismatch expected r%h g%h b%h actual r%h g%h b%h", $time,
                   want.red, want.green, want.blue, got.red, got.green, got.blue);
          errors <= errors + 1;
        end
      end
    end
    if (cycles > 400000) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_px.size() > 0 || in_tvalid || adjusted_px.size() > 0) @(posedge clk);
    repeat (hgca_pkg::NST + 5) @(posedge clk);
  endtask

  task automatic write_gain(logic [1:0] idx, logic [hgca_pkg::GAIN_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      hgca_pkg::CFG_HUE_GAIN: hue_g = val;
      hgca_pkg::CFG_SAT_GAIN: sat_g = val;
      default: val_g = val;
    endcase
    @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p = pixel_t'(24'($urandom));
    case ($urandom_range(0, 7))
      0: p.green = p.red;              // tie on a channel
      1: begin p.green = p.red; p.blue = p.red; end  // gray
      2: p.blue = p.red;
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    logic [hgca_pkg::GAIN_W-1:0] gset [0:5][0:2];
    hue_g = hgca_pkg::HUE_GAIN_RST;
    sat_g = hgca_pkg::SAT_GAIN_RST;
    val_g = hgca_pkg::VAL_GAIN_RST;
    gset = '{'{11'd1024, 11'd1024, 11'd1024}, '{11'd0, 11'd0, 11'd0},
             '{11'd2047, 11'd2047, 11'd2047}, '{11'd1500, 11'd1300, 11'd1800},
             '{11'd512, 11'd1024, 11'd300}, '{11'd102, 11'd768, 11'd768}};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset gains, extremes, gray, black, ties, every hue sector
    pending_px = '{24'h000000, 24'hffffff, 24'h808080, 24'h0000ff, 24'h00ff00,
                   24'hff0000, 24'h00ffff, 24'hff00ff, 24'hffff00, 24'h0080ff,
                   24'hff8000, 24'h80ff00, 24'h01ff00, 24'h0001ff, 24'hfe00ff,
                   24'h5a3c1e, 24'h102030, 24'haa55aa, 24'h0000ff, 24'h010101};
    // wait until every pixel is sent and the pipeline drains
    wait_idle();

    for (int s = 0; s < 6; s++) begin
      write_gain(hgca_pkg::CFG_HUE_GAIN, gset[s][0]);
      write_gain(hgca_pkg::CFG_SAT_GAIN, gset[s][1]);
      write_gain(hgca_pkg::CFG_VAL_GAIN, gset[s][2]);
      for (int i = 0; i < 100; i++) pending_px.push_back(rand_pixel());
      if (s == 3) begin
        // pause mid-stream until every pixel in flight has come back
        while (pending_px.size() > 50) @(posedge clk);
        send_hold = 1'b1;
        while (in_tvalid || adjusted_px.size() > 0) @(posedge clk);
        send_hold = 1'b0;
      end
      for (int i = 0; i < 100; i++) pending_px.push_back(rand_pixel());
      wait_idle();
    end

    // random gains too
    for (int s = 0; s < 4; s++) begin
      write_gain(hgca_pkg::CFG_HUE_GAIN, 11'($urandom_range(0, 2047)));
      write_gain(hgca_pkg::CFG_SAT_GAIN, 11'($urandom_range(0, 2047)));
      write_gain(hgca_pkg::CFG_VAL_GAIN, 11'($urandom_range(0, 2047)));
      for (int i = 0; i < 35; i++) pending_px.push_back(rand_pixel());
      wait_idle();
    end

    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
